>>> design/sdspi_pkg.sv
// Shared types, protocol constants and CRC helpers for the SD SPI command engine.
package sdspi_pkg;

  typedef struct packed {
    logic        mode;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [9:0]  recv_length;
    logic        app_command;
    logic [7:0]  rx_byte;
  } sdspi_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       exchange_needed;
    logic       select_active;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] response;
  } sdspi_out_t;

  localparam logic       MODE_START      = 1'b0;
  localparam logic [7:0] CMD_START_BITS  = 8'h40;
  localparam logic [7:0] IDLE_BYTE       = 8'hFF;
  localparam logic [7:0] DATA_TOKEN      = 8'hFE;
  localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [9:0] FRAME_LEN       = 10'd6;
  localparam logic [9:0] FRAME_CRC_POS   = 10'd5;
  localparam int         R1_ILLEGAL_BIT  = 2;
  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd255;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT   = 2'd1;
  localparam logic [1:0] STATUS_BAD_TOKEN = 2'd2;
  localparam logic [1:0] STATUS_CRC_FAIL  = 2'd3;

  // CRC7 (x^7 + x^3 + 1) advanced by one byte, most significant bit first.
  function automatic logic [6:0] crc7_add(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ 7'h09;
      end
    end
    return c;
  endfunction

  // CRC16-CCITT (0x1021) advanced by one byte.
  function automatic logic [15:0] crc16_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/sdspi_engine.sv
// Command engine state machine: transaction state, one step per byte exchange, result register.
module sdspi_engine #(
  parameter int MAX_RECEIVE = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sdspi_pkg::sdspi_in_t item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output sdspi_pkg::sdspi_out_t result
);
  import sdspi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_READY, PH_FRAME, PH_R1, PH_TOKEN, PH_DATA, PH_CRC_HI, PH_CRC_LO
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] response_wait_limit;
  logic [9:0]  byte_counter, byte_counter_next;
  logic [15:0] poll_counter, poll_counter_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [31:0] argument_shift, argument_shift_next;
  logic [6:0]  frame_crc7, frame_crc7_next;
  logic [15:0] data_crc16, data_crc16_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  r1_value, r1_value_next;
  logic        pending_app_command, pending_app_command_next;
  logic [9:0]  receive_count, receive_count_next;
  logic [5:0]  held_index, held_index_next;
  logic [31:0] held_argument, held_argument_next;
  logic [9:0]  held_length, held_length_next;
  logic        frame_fault, frame_fault_next;
  sdspi_out_t  result_next;

  function automatic logic [9:0] sat_length(input logic [9:0] len);
    return (32'(len) > MAX_RECEIVE) ? 10'(MAX_RECEIVE) : len;
  endfunction

  always_comb begin
    logic        load;
    logic [5:0]  load_idx;
    logic [31:0] load_arg;
    logic [9:0]  load_len;
    logic        done;
    logic        is_read;
    logic [7:0]  fbyte;
    logic [7:0]  rx;

    rx       = item.rx_byte;
    load     = 1'b0;
    load_idx = item.cmd_index;
    load_arg = item.argument;
    load_len = item.recv_length;
    done     = 1'b0;
    is_read  = (command_byte == (CMD_START_BITS | {2'b00, CMD_READ_SINGLE}))
            || (command_byte == (CMD_START_BITS | {2'b00, CMD_READ_MULTI}));
    fbyte    = IDLE_BYTE;

    phase_next               = phase;
    byte_counter_next        = byte_counter;
    poll_counter_next        = poll_counter;
    command_byte_next        = command_byte;
    argument_shift_next      = argument_shift;
    frame_crc7_next          = frame_crc7;
    data_crc16_next          = data_crc16;
    received_crc_next        = received_crc;
    r1_value_next            = r1_value;
    pending_app_command_next = pending_app_command;
    receive_count_next       = receive_count;
    held_index_next          = held_index;
    held_argument_next       = held_argument;
    held_length_next         = held_length;
    frame_fault_next         = frame_fault;

    result_next                 = '0;
    result_next.tx_byte         = IDLE_BYTE;
    result_next.exchange_needed = 1'b1;
    result_next.select_active   = 1'b1;

    if (item.mode == MODE_START) begin
      load = 1'b1;
      if (item.app_command) begin
        held_index_next          = item.cmd_index;
        held_argument_next       = item.argument;
        held_length_next         = sat_length(item.recv_length);
        pending_app_command_next = 1'b1;
        load_idx = CMD_APP;
        load_arg = '0;
        load_len = '0;
      end else begin
        pending_app_command_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_READY: begin
          if (rx == IDLE_BYTE) begin
            phase_next          = PH_FRAME;
            byte_counter_next   = '0;
            result_next.tx_byte = command_byte;
            // The frame CRC is accumulated as each frame byte goes out.
            frame_crc7_next     = crc7_add(7'd0, command_byte);
          end
        end
        PH_FRAME: begin
          if (rx != IDLE_BYTE) begin
            frame_fault_next = 1'b1;
          end
          byte_counter_next = byte_counter + 10'd1;
          unique case (byte_counter_next[2:0])
            3'd1:    fbyte = argument_shift[31:24];
            3'd2:    fbyte = argument_shift[23:16];
            3'd3:    fbyte = argument_shift[15:8];
            3'd4:    fbyte = argument_shift[7:0];
            default: fbyte = {frame_crc7, 1'b1};
          endcase
          if (byte_counter_next < FRAME_LEN) begin
            result_next.tx_byte = fbyte;
            if (byte_counter_next != FRAME_CRC_POS) begin
              frame_crc7_next = crc7_add(frame_crc7, fbyte);
            end
          end else if (frame_fault_next) begin
            done               = 1'b1;
            result_next.status = STATUS_TIMEOUT;
          end else begin
            phase_next        = PH_R1;
            poll_counter_next = response_wait_limit;
          end
        end
        PH_R1: begin
          if (rx == IDLE_BYTE) begin
            if (poll_counter == '0) begin
              done               = 1'b1;
              result_next.status = STATUS_TIMEOUT;
            end else begin
              poll_counter_next = poll_counter - 16'd1;
            end
          end else begin
            r1_value_next = rx;
            if (pending_app_command) begin
              pending_app_command_next = 1'b0;
              if (rx[R1_ILLEGAL_BIT]) begin
                done                 = 1'b1;
                result_next.response = rx;
              end else begin
                load     = 1'b1;
                load_idx = held_index;
                load_arg = held_argument;
                load_len = held_length;
              end
            end else if (is_read) begin
              if (rx != 8'd0) begin
                done                 = 1'b1;
                result_next.response = rx;
              end else begin
                phase_next = PH_TOKEN;
              end
            end else if (receive_count != '0) begin
              phase_next        = PH_DATA;
              byte_counter_next = '0;
            end else begin
              done                 = 1'b1;
              result_next.response = rx;
            end
          end
        end
        PH_TOKEN: begin
          if (rx == DATA_TOKEN) begin
            byte_counter_next = '0;
            phase_next        = (receive_count != '0) ? PH_DATA : PH_CRC_HI;
          end else if (rx != IDLE_BYTE) begin
            done                 = 1'b1;
            result_next.status   = STATUS_BAD_TOKEN;
            result_next.response = rx;
          end
        end
        PH_DATA: begin
          result_next.data_byte  = rx;
          result_next.data_valid = 1'b1;
          data_crc16_next        = crc16_add(data_crc16, rx);
          byte_counter_next      = byte_counter + 10'd1;
          if (byte_counter_next >= receive_count) begin
            if (is_read) begin
              phase_next = PH_CRC_HI;
            end else begin
              done                 = 1'b1;
              result_next.response = r1_value;
            end
          end
        end
        PH_CRC_HI: begin
          received_crc_next = {rx, 8'h00};
          phase_next        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc_next    = {received_crc[15:8], rx};
          done                 = 1'b1;
          result_next.response = r1_value;
          if (received_crc_next != data_crc16) begin
            result_next.status = STATUS_CRC_FAIL;
          end
        end
        default: begin
          result_next.exchange_needed = 1'b0;
          result_next.select_active   = 1'b0;
        end
      endcase
    end

    if (load) begin
      command_byte_next   = CMD_START_BITS | {2'b00, load_idx};
      argument_shift_next = load_arg;
      receive_count_next  = sat_length(load_len);
      frame_crc7_next     = '0;
      phase_next          = PH_READY;
      byte_counter_next   = '0;
      poll_counter_next   = '0;
      data_crc16_next     = '0;
      received_crc_next   = '0;
      r1_value_next       = '0;
      frame_fault_next    = 1'b0;
    end

    if (done) begin
      phase_next = PH_IDLE;
    end
    result_next.done_res = done;
    if (done || (item.mode != MODE_START && phase_next == PH_IDLE)) begin
      result_next.tx_byte         = IDLE_BYTE;
      result_next.exchange_needed = 1'b0;
      result_next.select_active   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_wait_limit <= WAIT_LIMIT_RESET;
      phase               <= PH_IDLE;
      byte_counter        <= '0;
      poll_counter        <= '0;
      command_byte        <= '0;
      argument_shift      <= '0;
      frame_crc7          <= '0;
      data_crc16          <= '0;
      received_crc        <= '0;
      r1_value            <= '0;
      pending_app_command <= 1'b0;
      receive_count       <= '0;
      held_index          <= '0;
      held_argument       <= '0;
      held_length         <= '0;
      frame_fault         <= 1'b0;
    end else begin
      if (cfg_we) begin
        response_wait_limit <= cfg_data;
      end
      if (step) begin
        phase               <= phase_next;
        byte_counter        <= byte_counter_next;
        poll_counter        <= poll_counter_next;
        command_byte        <= command_byte_next;
        argument_shift      <= argument_shift_next;
        frame_crc7          <= frame_crc7_next;
        data_crc16          <= data_crc16_next;
        received_crc        <= received_crc_next;
        r1_value            <= r1_value_next;
        pending_app_command <= pending_app_command_next;
        receive_count       <= receive_count_next;
        held_index          <= held_index_next;
        held_argument       <= held_argument_next;
        held_length         <= held_length_next;
        frame_fault         <= frame_fault_next;
      end
    end
    if (step) begin
      result <= result_next;
    end
  end

endmodule

>>> design/sd_spi_command_transaction.sv
// SD card SPI-mode command engine: one transaction per start, one step per SPI byte exchange.
// Each transaction on the input channel is either a command start or the byte that the card
// returned in one completed SPI exchange; each produces exactly one result transaction that
// gives the next byte to send, the chip select level, any received data byte, and, on the last
// step, the final status and R1 response. The block takes one input transaction per clock while
// res_ready lets results drain; each is held in the input register, then the step logic updates
// the engine state and the result register. Byte-wise CRC7 and CRC16 are folded in as bytes
// pass. The R1 poll limit is set through cfg_we and cfg_data; the user must write it only while
// no transaction is in flight, as the block itself does not enforce this.
module sd_spi_command_transaction #(
  parameter int MAX_RECEIVE = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sdspi_pkg::sdspi_in_t  in_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sdspi_pkg::sdspi_out_t res_item,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data
);
  import sdspi_pkg::*;

  logic      stage_valid;
  sdspi_in_t stage_item;
  logic      advance;
  logic      step;

  assign advance  = !res_valid || res_ready;
  assign step     = stage_valid && advance;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage_valid <= 1'b1;
      end else if (step) begin
        stage_valid <= 1'b0;
      end
      if (step) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

  sdspi_engine #(
    .MAX_RECEIVE(MAX_RECEIVE)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (stage_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (res_item)
  );

endmodule

>>> verif/sd_spi_command_transaction_tb.sv
// Self-checking testbench for the SD SPI command engine: directed table, then a reactive card.
`timescale 1ns / 1ps

module sd_spi_command_transaction_tb;
  import sdspi_pkg::*;

  localparam int RX_MAX = 512;
  localparam logic MODE_EXCHANGE = 1'b1;
  localparam sdspi_out_t NO_RES = '0;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT_READY, S_FRAME, S_R1, S_TOKEN, S_DATA, S_CRC_HI, S_CRC_LO
  } eng_state_t;

  typedef struct packed {
    sdspi_in_t  item;
    logic       known;
    sdspi_out_t res;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sdspi_in_t   in_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  sdspi_out_t  res_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  logic        calm = 1'b0;
  logic        hang_r1 = 1'b0;
  int          mismatches = 0;
  sdspi_out_t  owed_results[$];
  sdspi_out_t  oldest;

  // Shadow copy of the engine state.
  logic [15:0] wait_limit = WAIT_LIMIT_RESET;
  eng_state_t  eng_state = S_IDLE;
  logic [9:0]  byte_cnt = '0;
  logic [15:0] polls_left = '0;
  logic [7:0]  cmd_byte = '0;
  logic [31:0] arg_reg = '0;
  logic [6:0]  frame_crc = '0;
  logic [15:0] data_crc = '0;
  logic [15:0] card_crc = '0;
  logic [7:0]  r1_latched = '0;
  logic        app_pending = 1'b0;
  logic [9:0]  data_len = '0;
  logic [5:0]  saved_idx = '0;
  logic [31:0] saved_arg = '0;
  logic [9:0]  saved_len = '0;
  logic        frame_bad = 1'b0;

  sd_spi_command_transaction #(.MAX_RECEIVE(RX_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** sd_spi_command_transaction: FAILED **");
    $finish;
  end

  // CRC7 over the command byte and the argument, taken bit by bit.
  function automatic logic [6:0] crc7_of_frame(input logic [39:0] head);
    logic [6:0] r;
    logic       top;
    r = '0;
    for (int i = 39; i >= 0; i--) begin
      top = r[6] ^ head[i];
      r = {r[5:0], 1'b0} ^ (top ? 7'h09 : 7'h00);
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      top = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (top ? 16'h1021 : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [9:0] clamp_len(input logic [9:0] len);
    return (len > RX_MAX) ? 10'(RX_MAX) : len;
  endfunction

  function automatic logic [7:0] frame_byte_at(input logic [9:0] k);
    case (k)
      10'd0: return cmd_byte;
      10'd1: return arg_reg[31:24];
      10'd2: return arg_reg[23:16];
      10'd3: return arg_reg[15:8];
      10'd4: return arg_reg[7:0];
      default: return {frame_crc, 1'b1};
    endcase
  endfunction

  function automatic logic reading_block();
    return cmd_byte[5:0] == CMD_READ_SINGLE || cmd_byte[5:0] == CMD_READ_MULTI;
  endfunction

  function automatic void load_cmd(input logic [5:0] idx, input logic [31:0] a,
                                   input logic [9:0] len);
    cmd_byte   = CMD_START_BITS | {2'b00, idx};
    arg_reg    = a;
    data_len   = clamp_len(len);
    frame_crc  = crc7_of_frame({cmd_byte, a});
    eng_state  = S_WAIT_READY;
    byte_cnt   = '0;
    polls_left = '0;
    data_crc   = '0;
    card_crc   = '0;
    r1_latched = '0;
    frame_bad  = 1'b0;
  endfunction

  // Advances the shadow engine by one transaction and returns the result it owes.
  function automatic sdspi_out_t engine_step(input sdspi_in_t it);
    sdspi_out_t r;
    logic       finish;
    logic [7:0] rx;
    r = '0;
    r.tx_byte = IDLE_BYTE;
    r.exchange_needed = 1'b1;
    r.select_active = 1'b1;
    finish = 1'b0;
    rx = it.rx_byte;
    if (it.mode == MODE_START) begin
      if (it.app_command) begin
        saved_idx = it.cmd_index;
        saved_arg = it.argument;
        saved_len = clamp_len(it.recv_length);
        app_pending = 1'b1;
        load_cmd(CMD_APP, 32'd0, 10'd0);
      end else begin
        app_pending = 1'b0;
        load_cmd(it.cmd_index, it.argument, it.recv_length);
      end
    end else begin
      case (eng_state)
        S_WAIT_READY: begin
          if (rx == IDLE_BYTE) begin
            eng_state = S_FRAME;
            byte_cnt = '0;
            r.tx_byte = frame_byte_at(10'd0);
          end
        end
        S_FRAME: begin
          if (rx != IDLE_BYTE) frame_bad = 1'b1;
          byte_cnt = byte_cnt + 10'd1;
          if (byte_cnt < FRAME_LEN) begin
            r.tx_byte = frame_byte_at(byte_cnt);
          end else if (frame_bad) begin
            finish = 1'b1;
            r.status = STATUS_TIMEOUT;
          end else begin
            eng_state = S_R1;
            polls_left = wait_limit;
          end
        end
        S_R1: begin
          if (rx == IDLE_BYTE) begin
            if (polls_left == 0) begin
              finish = 1'b1;
              r.status = STATUS_TIMEOUT;
            end else begin
              polls_left = polls_left - 16'd1;
            end
          end else begin
            r1_latched = rx;
            if (app_pending) begin
              app_pending = 1'b0;
              if (rx[R1_ILLEGAL_BIT]) begin
                finish = 1'b1;
                r.response = rx;
              end else begin
                load_cmd(saved_idx, saved_arg, saved_len);
              end
            end else if (reading_block()) begin
              if (rx != 8'h00) begin
                finish = 1'b1;
                r.response = rx;
              end else begin
                eng_state = S_TOKEN;
              end
            end else if (data_len > 0) begin
              eng_state = S_DATA;
              byte_cnt = '0;
            end else begin
              finish = 1'b1;
              r.response = rx;
            end
          end
        end
        S_TOKEN: begin
          if (rx == DATA_TOKEN) begin
            byte_cnt = '0;
            eng_state = (data_len > 0) ? S_DATA : S_CRC_HI;
          end else if (rx != IDLE_BYTE) begin
            finish = 1'b1;
            r.status = STATUS_BAD_TOKEN;
            r.response = rx;
          end
        end
        S_DATA: begin
          r.data_byte = rx;
          r.data_valid = 1'b1;
          data_crc = crc16_step(data_crc, rx);
          byte_cnt = byte_cnt + 10'd1;
          if (byte_cnt >= data_len) begin
            if (reading_block()) begin
              eng_state = S_CRC_HI;
            end else begin
              finish = 1'b1;
              r.response = r1_latched;
            end
          end
        end
        S_CRC_HI: begin
          card_crc = {rx, 8'h00};
          eng_state = S_CRC_LO;
        end
        S_CRC_LO: begin
          card_crc = {card_crc[15:8], rx};
          finish = 1'b1;
          r.response = r1_latched;
          if (card_crc != data_crc) r.status = STATUS_CRC_FAIL;
        end
        default: ;
      endcase
    end
    if (finish) begin
      eng_state = S_IDLE;
      r.done_res = 1'b1;
    end
    if (finish || (it.mode != MODE_START && eng_state == S_IDLE)) begin
      r.tx_byte = IDLE_BYTE;
      r.exchange_needed = 1'b0;
      r.select_active = 1'b0;
    end
    return r;
  endfunction

  function automatic sdspi_in_t start_item(input logic [5:0] idx, input logic [31:0] a,
                                           input logic [9:0] len, input logic app);
    sdspi_in_t it;
    it = '0;
    it.mode = MODE_START;
    it.cmd_index = idx;
    it.argument = a;
    it.recv_length = len;
    it.app_command = app;
    return it;
  endfunction

  function automatic sdspi_in_t xchg(input logic [7:0] b);
    sdspi_in_t it;
    it = '0;
    it.mode = MODE_EXCHANGE;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic sdspi_out_t busy_res();
    sdspi_out_t r;
    r = '0;
    r.tx_byte = IDLE_BYTE;
    r.exchange_needed = 1'b1;
    r.select_active = 1'b1;
    return r;
  endfunction

  function automatic sdspi_out_t final_res(input logic done, input logic [1:0] st,
                                           input logic [7:0] resp);
    sdspi_out_t r;
    r = '0;
    r.tx_byte = IDLE_BYTE;
    r.done_res = done;
    r.status = st;
    r.response = resp;
    return r;
  endfunction

  function automatic sdspi_in_t noise_fields();
    sdspi_in_t it;
    it.mode = 1'($urandom);
    it.cmd_index = 6'($urandom);
    it.argument = $urandom;
    it.recv_length = 10'($urandom);
    it.app_command = 1'($urandom);
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  function automatic sdspi_in_t random_start();
    sdspi_in_t   it;
    int unsigned r;
    it = noise_fields();
    it.mode = MODE_START;
    r = $urandom_range(99);
    if (r < 35) it.cmd_index = CMD_READ_SINGLE;
    else if (r < 55) it.cmd_index = CMD_READ_MULTI;
    else if (r < 60) it.cmd_index = CMD_APP;
    // Most transfers are short; a few go past the buffer size to hit saturation.
    r = $urandom_range(99);
    if (r < 85) it.recv_length = 10'($urandom_range(8));
    else if (r < 98) it.recv_length = 10'($urandom_range(40, 9));
    else it.recv_length = 10'($urandom_range(1023, 500));
    it.app_command = ($urandom_range(99) < 25);
    hang_r1 = (wait_limit <= 16'd300) && ($urandom_range(99) < 6);
    return it;
  endfunction

  // Plays the card: picks the next byte from where the shadow engine stands.
  function automatic sdspi_in_t card_item();
    sdspi_in_t   it;
    int unsigned r;
    it = noise_fields();
    it.mode = MODE_EXCHANGE;
    r = $urandom_range(99);
    if (eng_state == S_IDLE) return (r < 5) ? it : random_start();
    if (r == 0) return random_start();
    r = $urandom_range(99);
    case (eng_state)
      S_WAIT_READY: if (r < 75) it.rx_byte = IDLE_BYTE;
      S_FRAME: if (r < 97) it.rx_byte = IDLE_BYTE;
      S_R1: begin
        if (hang_r1 || (polls_left != 0 && r < 50)) begin
          it.rx_byte = IDLE_BYTE;
        end else begin
          it.rx_byte = 8'($urandom_range(254));
          if (app_pending) it.rx_byte[R1_ILLEGAL_BIT] = ($urandom_range(99) < 30);
          else if ($urandom_range(99) < (reading_block() ? 75 : 40)) it.rx_byte = 8'h00;
        end
      end
      S_TOKEN: begin
        if (r < 40) it.rx_byte = IDLE_BYTE;
        else if (r < 90) it.rx_byte = DATA_TOKEN;
      end
      S_CRC_HI: if (r < 88) it.rx_byte = data_crc[15:8];
      S_CRC_LO: if (r < 88) it.rx_byte = data_crc[7:0];
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input sdspi_in_t it, input logic known, input sdspi_out_t res);
    sdspi_out_t predicted;
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = engine_step(it);
    owed_results.push_back(known ? res : predicted);
  endtask

  // The limit only changes with nothing in flight.
  task automatic set_wait_limit(input logic [15:0] v);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    wait_limit = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_ready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        $error("result transaction with none outstanding: 0x%0h", res_item);
      end else begin
        oldest = owed_results.pop_front();
        check_field("tx_byte", 32'(oldest.tx_byte), 32'(res_item.tx_byte));
        check_field("exchange_needed", 32'(oldest.exchange_needed),
                    32'(res_item.exchange_needed));
        check_field("select_active", 32'(oldest.select_active), 32'(res_item.select_active));
        check_field("data_byte", 32'(oldest.data_byte), 32'(res_item.data_byte));
        check_field("data_valid", 32'(oldest.data_valid), 32'(res_item.data_valid));
        check_field("done_res", 32'(oldest.done_res), 32'(res_item.done_res));
        check_field("status", 32'(oldest.status), 32'(res_item.status));
        check_field("response", 32'(oldest.response), 32'(res_item.response));
      end
    end
  end

  initial begin
    dir_row_t    script[$];
    logic [15:0] plan_limit [5];
    int          plan_items [5];
    int          counted;
    sdspi_in_t   it;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_wait_limit(16'd0);

    // Exchange while idle, then a start that is abandoned in the middle of its frame.
    script.push_back({xchg(8'h00), 1'b1, final_res(1'b0, STATUS_OK, 8'h00)});
    script.push_back({start_item(6'd0, 32'd0, 10'd0, 1'b0), 1'b1, busy_res()});
    script.push_back({xchg(8'h00), 1'b0, NO_RES});
    script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    // Application command with every field at its top; a bad echo spoils the CMD55 frame.
    script.push_back({start_item(6'd63, 32'hFFFF_FFFF, 10'h3FF, 1'b1), 1'b1, busy_res()});
    script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    script.push_back({xchg(8'h00), 1'b0, NO_RES});
    repeat (3) script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    script.push_back({xchg(IDLE_BYTE), 1'b1, final_res(1'b1, STATUS_TIMEOUT, 8'h00)});
    // Block read whose R1 never comes: with a limit of zero one poll times out.
    script.push_back({start_item(CMD_READ_SINGLE, 32'h1234_5678, 10'd2, 1'b0), 1'b1,
                      busy_res()});
    repeat (7) script.push_back({xchg(IDLE_BYTE), 1'b0, NO_RES});
    script.push_back({xchg(IDLE_BYTE), 1'b1, final_res(1'b1, STATUS_TIMEOUT, 8'h00)});

    foreach (script[i]) send_item(script[i].item, script[i].known, script[i].res);

    plan_limit[0] = 16'hFFFF;
    plan_limit[1] = 16'd3;
    plan_limit[2] = WAIT_LIMIT_RESET;
    plan_limit[3] = 16'($urandom_range(40, 1));
    plan_limit[4] = 16'd0;
    plan_items[0] = 300;
    plan_items[1] = 350;
    plan_items[2] = 350;
    plan_items[3] = 300;
    plan_items[4] = 300;

    for (int p = 0; p < 5; p++) begin
      set_wait_limit(plan_limit[p]);
      calm = (p == 1);
      counted = 0;
      while (counted < plan_items[p] || eng_state != S_IDLE) begin
        it = card_item();
        if (!(it.mode == MODE_EXCHANGE && eng_state == S_IDLE)) counted++;
        send_item(it, 1'b0, NO_RES);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sd_spi_command_transaction: PASSED **");
    end else begin
      $display("** sd_spi_command_transaction: FAILED **");
    end
    $finish;
  end

endmodule
